// ===== rtl/lwpq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwpq_pkg: shared types and constants for the lock wait priority queue
// Payload structs, operation and status codes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package lwpq_pkg;

   localparam int NUM_PROCS  = 64;
   localparam int NUM_QUEUES = 16;
   localparam int PW = $clog2(NUM_PROCS);
   localparam int QW = $clog2(NUM_QUEUES);
   // Link encoding: values >= NUM_PROCS mark a queue end.
   localparam int LW = $clog2(NUM_PROCS + NUM_QUEUES);
   localparam logic [31:0] GRACE_RESET = 32'd1000;

   localparam logic [1:0] KIND_INSERT = 2'd0;
   localparam logic [1:0] KIND_REMOVE = 2'd1;

   localparam logic [1:0] STATUS_OK          = 2'd0;
   localparam logic [1:0] STATUS_DUP_WAIT    = 2'd1;
   localparam logic [1:0] STATUS_NOT_WAITING = 2'd2;

   typedef struct packed {
      logic [1:0]         kind;
      logic [3:0]         queue_id;
      logic [5:0]         proc_id;
      logic signed [15:0] wait_prio;
      logic               is_write;
      logic [31:0]        now_time;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic               queue_empty;
      logic [5:0]         first_proc;
      logic signed [15:0] first_prio;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_WALK_RD,
      ST_WALK_CMP,
      ST_INS_LINK,
      ST_REM_RD,
      ST_REM_LINK,
      ST_REPORT_RD,
      ST_REPORT,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic capture;     // latch request
      logic walk_start;  // load cursor from queue front
      logic walk_read;   // read entry at cursor
      logic walk_step;   // advance cursor
      logic ins_link;    // write new entry and links
      logic rem_read;    // read entry to be removed
      logic rem_link;    // unlink
      logic front_read;  // read front entry of named queue
      logic report;      // build response
      logic set_status;
      logic [1:0] status;
   } cmd_type;

   typedef struct packed {
      logic is_insert;
      logic is_remove;
      logic waiting;     // named process already waiting
      logic ins_ok;      // insert targets a valid queue
      logic walk_done;   // position found
   } sts_type;

endpackage

// ===== rtl/lwpq_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwpq_ctrl: operation sequencer
// Steps each request through decode, queue walk or unlink, front report and
// response hand-off.
// ----------------------------------------------------------------------------
module lwpq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  lwpq_pkg::sts_type sts,
   output lwpq_pkg::cmd_type cmd
);
   import lwpq_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:     if (req_valid) state_in = ST_DECODE;
         ST_DECODE: begin
            priority if (sts.is_insert && !sts.waiting && sts.ins_ok) state_in = ST_WALK_RD;
            else if (sts.is_remove && sts.waiting) state_in = ST_REM_RD;
            else state_in = ST_REPORT_RD;
         end
         ST_WALK_RD:  state_in = ST_WALK_CMP;
         ST_WALK_CMP: state_in = sts.walk_done ? ST_INS_LINK : ST_WALK_RD;
         ST_INS_LINK: state_in = ST_REPORT_RD;
         ST_REM_RD:   state_in = ST_REM_LINK;
         ST_REM_LINK: state_in = ST_REPORT_RD;
         ST_REPORT_RD: state_in = ST_REPORT;
         ST_REPORT:   state_in = ST_RESP;
         ST_RESP:     if (rsp_ready) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.capture = req_valid;
         end
         ST_DECODE: begin
            cmd.set_status = 1'b1;
            priority if (sts.is_insert && sts.waiting) cmd.status = STATUS_DUP_WAIT;
            else if (sts.is_remove && !sts.waiting) cmd.status = STATUS_NOT_WAITING;
            else cmd.status = STATUS_OK;
            cmd.walk_start = sts.is_insert && !sts.waiting && sts.ins_ok;
         end
         ST_WALK_RD:   cmd.walk_read = 1'b1;
         ST_WALK_CMP:  cmd.walk_step = !sts.walk_done;
         ST_INS_LINK:  cmd.ins_link = 1'b1;
         ST_REM_RD:    cmd.rem_read = 1'b1;
         ST_REM_LINK:  cmd.rem_link = 1'b1;
         ST_REPORT_RD: cmd.front_read = 1'b1;
         ST_REPORT:    cmd.report = 1'b1;
         ST_RESP:      rsp_valid = 1'b1;
         default: ;
      endcase
   end

endmodule

// ===== rtl/lwpq_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwpq_dp: queue storage and link datapath
// Entry memories, per-queue front table, the walk cursor and the response
// register.
// ----------------------------------------------------------------------------
module lwpq_dp (
   input  logic              clock,
   input  logic              reset,
   input  lwpq_pkg::req_type req_data,
   input  logic [31:0]       csr_wdata,
   input  logic              csr_we,
   input  lwpq_pkg::cmd_type cmd,
   output lwpq_pkg::sts_type sts,
   output lwpq_pkg::rsp_type rsp_data
);
   import lwpq_pkg::*;

   localparam logic [LW-1:0] TAIL = LW'(NUM_PROCS);

   // Entry record kept in one memory; read data registered.
   typedef struct packed {
      logic signed [15:0] prio;
      logic               writer;
      logic [31:0]        stamp;
   } entry_type;

   entry_type mem [NUM_PROCS];
   entry_type rd_ff;

   logic [NUM_QUEUES-1:0] qne_ff;
   logic [PW-1:0]         qfront [NUM_QUEUES];
   logic [NUM_PROCS-1:0]  waiting_ff;
   logic [31:0]           grace_ff;
   req_type               req_ff;
   logic [1:0]            status_ff;
   logic [LW-1:0]         cur_ff, prev_ff;
   logic                  walk_done;
   rsp_type               rsp_ff;
   logic [LW-1:0]         rem_a, rem_b, walk_after;

   logic [PW-1:0] p;
   logic [QW-1:0] q;
   assign p = req_ff.proc_id[PW-1:0];
   assign q = req_ff.queue_id[QW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         grace_ff <= GRACE_RESET;
      end else if (csr_we) begin
         grace_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) req_ff <= req_data;
      if (cmd.set_status) status_ff <= cmd.status;
   end

   // Walk: stop before the first lower-priority entry, or an equal reader
   // still inside the grace window when inserting a writer.
   logic cur_end, pass;
   logic [31:0] age;
   assign cur_end = cur_ff >= TAIL;
   assign age = req_ff.now_time - rd_ff.stamp;
   assign pass = (req_ff.wait_prio > rd_ff.prio) ||
                 (req_ff.is_write && req_ff.wait_prio == rd_ff.prio &&
                  !rd_ff.writer && age < grace_ff);

   logic [PW-1:0] rd_addr;
   always_comb begin
      rd_addr = cur_ff[PW-1:0];
      if (cmd.rem_read) rd_addr = p;
      else if (cmd.front_read) rd_addr = qfront[q];
   end

   always_ff @(posedge clock) begin
      if (cmd.walk_read || cmd.rem_read || cmd.front_read) rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.walk_start) begin
         cur_ff  <= qne_ff[q] ? LW'(qfront[q]) : TAIL;
         prev_ff <= LW'(NUM_PROCS + int'(q));
      end else if (cmd.walk_step) begin
         prev_ff <= cur_ff;
         cur_ff  <= walk_after;
      end
   end

   // Done is evaluated in the compare cycle; a queue end needs no read.
   assign walk_done = cur_end || pass;

   // Link updates: one write port on the record memory is used per cycle for
   // the new entry; neighbor link fields are narrow side arrays.
   logic [LW-1:0] after_arr  [NUM_PROCS];
   logic [LW-1:0] before_arr [NUM_PROCS];

   always_ff @(posedge clock) begin
      if (cmd.ins_link) begin
         mem[p] <= '{prio: req_ff.wait_prio, writer: req_ff.is_write,
                     stamp: req_ff.now_time};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.ins_link) begin
         after_arr[p]  <= cur_end ? TAIL : cur_ff;
         before_arr[p] <= prev_ff;
         if (prev_ff < TAIL) after_arr[prev_ff[PW-1:0]] <= LW'(p);
         if (!cur_end) before_arr[cur_ff[PW-1:0]] <= LW'(p);
      end else if (cmd.rem_link) begin
         if (rem_b < TAIL) after_arr[rem_b[PW-1:0]] <= (rem_a < TAIL) ? rem_a : TAIL;
         if (rem_a < TAIL) before_arr[rem_a[PW-1:0]] <= rem_b;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rem_read) begin
         rem_a <= after_arr[p];
         rem_b <= before_arr[p];
      end
      if (cmd.walk_read) walk_after <= after_arr[cur_ff[PW-1:0]];
   end

   logic [LW-1:0] rem_qq;
   assign rem_qq = rem_b - TAIL;

   always_ff @(posedge clock) begin
      if (reset) begin
         qne_ff     <= '0;
         waiting_ff <= '0;
      end else if (cmd.ins_link) begin
         waiting_ff[p] <= 1'b1;
         if (prev_ff >= TAIL) qne_ff[q] <= 1'b1;
      end else if (cmd.rem_link) begin
         waiting_ff[p] <= 1'b0;
         if (rem_b >= TAIL && rem_qq < LW'(NUM_QUEUES) && rem_a >= TAIL)
            qne_ff[rem_qq[QW-1:0]] <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.ins_link && prev_ff >= TAIL) qfront[q] <= p;
      else if (cmd.rem_link && rem_b >= TAIL && rem_qq < LW'(NUM_QUEUES) && rem_a < TAIL)
         qfront[rem_qq[QW-1:0]] <= rem_a[PW-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.report) begin
         rsp_ff.status <= status_ff;
         if (qne_ff[q]) begin
            rsp_ff.queue_empty <= 1'b0;
            rsp_ff.first_proc  <= 6'(qfront[q]);
            rsp_ff.first_prio  <= rd_ff.prio;
         end else begin
            rsp_ff.queue_empty <= 1'b1;
            rsp_ff.first_proc  <= '0;
            rsp_ff.first_prio  <= '0;
         end
      end
   end

   assign sts.is_insert = req_ff.kind == KIND_INSERT;
   assign sts.is_remove = req_ff.kind == KIND_REMOVE;
   assign sts.waiting   = waiting_ff[p];
   assign sts.ins_ok    = 1'b1;
   assign sts.walk_done = walk_done;
   assign rsp_data = rsp_ff;

endmodule

// ===== rtl/lock_wait_priority_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lock_wait_priority_queue: priority-ordered reader/writer wait queues
// Sixteen wait queues of up to 64 process entries as doubly linked lists.
// ----------------------------------------------------------------------------
// One operation at a time. An insert walks the named queue from its front,
// with a record read and then a compare for each entry visited; a remove
// reads and unlinks its entry instead, and a query skips both. Each one then
// reads the queue front and builds its report before the result is offered.
// The result waits in an output register until it is taken.
module lock_wait_priority_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  lwpq_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output lwpq_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [31:0]       csr_wdata
);
   import lwpq_pkg::*;

   cmd_type cmd;
   sts_type sts;

   lwpq_ctrl u_ctrl (.clock, .reset, .req_valid, .req_ready, .rsp_valid,
                     .rsp_ready, .sts, .cmd);
   lwpq_dp u_dp (.clock, .reset, .req_data, .csr_wdata, .csr_we, .cmd, .sts,
                 .rsp_data);

endmodule

// ===== rtl/lwpq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwpq_checker: port-level checks
// Observes the top-level ports over time.
// ----------------------------------------------------------------------------
module lwpq_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input lwpq_pkg::rsp_type rsp_data
);
   import lwpq_pkg::*;

   // A request transfer must not be taken while a result is still offered.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("ready while result pending");

   // After a request transfer the next cycle holds no result yet.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !rsp_valid) else $error("result too early");

   // An empty queue reports zero front fields.
   a_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.queue_empty) |-> (rsp_data.first_proc == '0 &&
      rsp_data.first_prio == '0)) else $error("empty report not zero");

   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status != 2'd3) else $error("bad status");

   // A stalled result stays offered and unchanged.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("result dropped or changed while stalled");

endmodule

bind lock_wait_priority_queue lwpq_checker u_chk (.clock, .reset, .req_valid,
   .req_ready, .rsp_valid, .rsp_ready, .rsp_data);
